FILE: design/fit_based_block_allocator_assert.svh
// Assertion macros shared by the fit-based block allocator RTL.
// Depends on clk_i and rst_ni being present in the module that uses them.
`ifndef FIT_BASED_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIT_BASED_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FBBA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define FBBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: design/fbba_pkg.sv
// Shared types and constants of the fit-based block allocator.
// No dependencies; imported by the allocator top level and the bench.
package fbba_pkg;

  localparam int NUM_BLOCKS = 8;
  localparam int SIZE_BITS  = 16;
  localparam int BLK_W      = 3;
  localparam int OP_W       = 2;
  localparam int STS_W      = 2;
  localparam int MODE_W     = 2;
  localparam int BIU_W      = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

  localparam logic [BIU_W-1:0] BIU_RESET = 4'd8;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_ALLOC   = 2'd1,
    OP_RESTORE = 2'd2
  } op_e;

  typedef enum logic [MODE_W-1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_e;

  typedef enum logic [STS_W-1:0] {
    STS_DONE  = 2'd0,
    STS_ALLOC = 2'd1,
    STS_NOFIT = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIT_MODE      = 1'b0,
    CFG_BLOCKS_IN_USE = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RESTORE,
    S_WB,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [BLK_W-1:0]     block_index;
    logic [SIZE_BITS-1:0] size_value;
  } fbba_in_t;

  typedef struct packed {
    logic [STS_W-1:0]     status;
    logic [BLK_W-1:0]     chosen_block;
    logic [SIZE_BITS-1:0] remaining_after;
  } fbba_out_t;

endpackage

FILE: design/fbba_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fbba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/fit_based_block_allocator.sv
// Fit-based block allocator top level: table of block sizes in two RAMs plus scan control.
// Depends on fbba_pkg, fbba_ram and fit_based_block_allocator_assert.svh.
//
// Holds a table of NUM_BLOCKS memory blocks, each with an original and a
// remaining size, in two small RAMs with a registered read. One
// transaction in gives one transaction out. A load writes both sizes of one
// block. A restore copies every original size into the remaining sizes, one
// entry per cycle through the RAM read port. An allocate streams the
// remaining sizes of the scanned blocks through the read port, one per cycle,
// compares each against the request as it arrives, then writes the chosen
// block back. An allocate or restore runs through its reads, then a drain
// of the last read still in flight; an allocate then passes the write-back
// state. Every transaction ends in the result state, where the result enters
// the output register on the same edge as the block returns to idle. Items
// are worked one at a time; the next one is accepted as soon as the previous
// result sits in the output register, even if that result has not yet been
// taken. Fit mode 3 behaves as first fit, blocks_in_use of zero reports no
// fit. Every entry carries a valid bit cleared by reset, so unwritten entries
// read as zero and no clearing pass is needed.
module fit_based_block_allocator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fbba_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [fbba_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  fbba_pkg::fbba_in_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output fbba_pkg::fbba_out_t                 out_data_o
);

  import fbba_pkg::*;

  // Configuration registers.
  logic [MODE_W-1:0] fit_mode_q;
  logic [BIU_W-1:0]  biu_q;

  // Sequencer state.
  state_e            state_q, state_d;
  fbba_in_t          item_q;
  logic [CNT_W-1:0]  limit_q, limit_d;
  logic [CNT_W-1:0]  cnt_q;
  logic              pend_q;
  logic [BLK_W-1:0]  pidx_q;

  // Best candidate so far.
  logic                 found_q;
  logic [BLK_W-1:0]     pick_q;
  logic [SIZE_BITS-1:0] pick_val_q;

  // Result staging and output register.
  fbba_out_t res_q, res_d;
  logic      res_load;
  fbba_out_t out_q;
  logic      out_valid_q;
  logic      out_load;

  // Per-entry valid bits; an invalid entry reads as zero.
  logic [NUM_BLOCKS-1:0] orig_vld_q;
  logic [NUM_BLOCKS-1:0] rem_vld_q;

  // RAM ports.
  logic                 orig_we, orig_re;
  logic [BLK_W-1:0]     orig_waddr, orig_raddr;
  logic [SIZE_BITS-1:0] orig_wdata, orig_rdata;
  logic                 rem_we, rem_re;
  logic [BLK_W-1:0]     rem_waddr, rem_raddr;
  logic [SIZE_BITS-1:0] rem_wdata, rem_rdata;

  // Datapath helpers.
  logic                 accept;
  logic                 issue;
  logic                 sweep_done;
  logic [SIZE_BITS-1:0] rem_val;
  logic [SIZE_BITS-1:0] orig_val;
  logic                 take;
  logic [SIZE_BITS-1:0] new_rem;
  logic                 load_hit;

  // Output checks.
  logic                 out_nogrant;
  logic                 out_zero;

  fbba_ram #(.WIDTH(SIZE_BITS), .DEPTH(NUM_BLOCKS)) u_orig_ram (
    .clk_i   (clk_i),
    .we_i    (orig_we),
    .waddr_i (orig_waddr),
    .wdata_i (orig_wdata),
    .re_i    (orig_re),
    .raddr_i (orig_raddr),
    .rdata_o (orig_rdata)
  );

  fbba_ram #(.WIDTH(SIZE_BITS), .DEPTH(NUM_BLOCKS)) u_rem_ram (
    .clk_i   (clk_i),
    .we_i    (rem_we),
    .waddr_i (rem_waddr),
    .wdata_i (rem_wdata),
    .re_i    (rem_re),
    .raddr_i (rem_raddr),
    .rdata_o (rem_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Issue one read per cycle while the sweep counter is below its limit.
  assign issue      = ((state_q == S_SCAN) || (state_q == S_RESTORE)) && (cnt_q < limit_q);
  assign sweep_done = !issue && !pend_q;

  assign rem_val  = rem_vld_q[pidx_q]  ? rem_rdata  : '0;
  assign orig_val = orig_vld_q[pidx_q] ? orig_rdata : '0;
  assign new_rem  = pick_val_q - item_q.size_value;
  assign load_hit = (CNT_W'(in_data_i.block_index) < CNT_W'(NUM_BLOCKS));

  assign out_nogrant = out_valid_o && (out_data_o.status != STS_ALLOC);
  assign out_zero    = (out_data_o.chosen_block == '0) && (out_data_o.remaining_after == '0);

  // Candidate selection; ties keep the lower index.
  always_comb begin
    take = 1'b0;
    if (rem_val >= item_q.size_value) begin
      if (!found_q) begin
        take = 1'b1;
      end else if ((fit_mode_q == FIT_BEST) && (rem_val < pick_val_q)) begin
        take = 1'b1;
      end else if ((fit_mode_q == FIT_WORST) && (rem_val > pick_val_q)) begin
        take = 1'b1;
      end
    end
  end

  // Scan limit for a newly accepted item.
  always_comb begin
    case (in_data_i.op)
      OP_RESTORE: limit_d = CNT_W'(NUM_BLOCKS);
      OP_ALLOC: begin
        if (biu_q > BIU_W'(NUM_BLOCKS)) begin
          limit_d = CNT_W'(NUM_BLOCKS);
        end else begin
          limit_d = CNT_W'(biu_q);
        end
      end
      default: limit_d = '0;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_data_i.op)
            OP_ALLOC:   state_d = S_SCAN;
            OP_RESTORE: state_d = S_RESTORE;
            default:    state_d = S_RESULT;
          endcase
        end
      end
      S_SCAN: begin
        if (sweep_done) begin
          state_d = S_WB;
        end
      end
      S_RESTORE: begin
        if (sweep_done) begin
          state_d = S_RESULT;
        end
      end
      S_WB:     state_d = S_RESULT;
      S_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // RAM controls and result staging.
  always_comb begin
    orig_we    = 1'b0;
    orig_waddr = in_data_i.block_index;
    orig_wdata = in_data_i.size_value;
    orig_re    = 1'b0;
    orig_raddr = cnt_q[BLK_W-1:0];
    rem_we     = 1'b0;
    rem_waddr  = in_data_i.block_index;
    rem_wdata  = in_data_i.size_value;
    rem_re     = 1'b0;
    rem_raddr  = cnt_q[BLK_W-1:0];
    res_load   = 1'b0;
    res_d      = '0;
    out_load   = 1'b0;
    case (state_q)
      S_IDLE: begin
        // Load writes both tables at once; every accepted op starts from a clean result.
        if (accept) begin
          res_load = 1'b1;
          if ((in_data_i.op == OP_LOAD) && load_hit) begin
            orig_we = 1'b1;
            rem_we  = 1'b1;
          end
        end
      end
      S_SCAN: begin
        rem_re = issue;
      end
      S_RESTORE: begin
        orig_re   = issue;
        rem_we    = pend_q;
        rem_waddr = pidx_q;
        rem_wdata = orig_val;
      end
      S_WB: begin
        res_load = 1'b1;
        if (found_q) begin
          rem_we             = 1'b1;
          rem_waddr          = pick_q;
          rem_wdata          = new_rem;
          res_d.status       = STS_ALLOC;
          res_d.chosen_block = pick_q;
          res_d.remaining_after = new_rem;
        end else begin
          res_d.status = STS_NOFIT;
        end
      end
      S_RESULT: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fit_mode_q  <= FIT_FIRST;
      biu_q       <= BIU_RESET;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      orig_vld_q  <= '0;
      rem_vld_q   <= '0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FIT_MODE:      fit_mode_q <= cfg_wdata_i[MODE_W-1:0];
          CFG_BLOCKS_IN_USE: biu_q      <= cfg_wdata_i[BIU_W-1:0];
          default: ;
        endcase
      end

      // Advance the sweep counter; the read issued now returns next cycle.
      if (accept) begin
        cnt_q <= '0;
      end else if (issue) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      pend_q <= issue;

      if (accept) begin
        found_q <= 1'b0;
      end else if ((state_q == S_SCAN) && pend_q && take) begin
        found_q <= 1'b1;
      end

      if (orig_we) begin
        orig_vld_q[orig_waddr] <= 1'b1;
      end
      if (rem_we) begin
        rem_vld_q[rem_waddr] <= 1'b1;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q  <= in_data_i;
      limit_q <= limit_d;
    end
    if (issue) begin
      pidx_q <= cnt_q[BLK_W-1:0];
    end
    if ((state_q == S_SCAN) && pend_q && take) begin
      pick_q     <= pidx_q;
      pick_val_q <= rem_val;
    end
    if (res_load) begin
      res_q <= res_d;
    end
    if (out_load) begin
      out_q <= res_q;
    end
  end

`include "fit_based_block_allocator_assert.svh"

  // An accepted transaction always leaves the idle state.
  `FBBA_ASSERT_NEXT(a_accept_leaves_idle, accept, state_q != S_IDLE)
  // A granted block lies inside the scanned range.
  `FBBA_ASSERT_IMPL(a_pick_in_range, (state_q == S_WB) && found_q, CNT_W'(pick_q) < limit_q)
  // Non-grant results carry zero block and zero remainder.
  `FBBA_ASSERT_IMPL(a_nogrant_zero, out_nogrant, out_zero)
  // A waiting result is never overwritten.
  `FBBA_ASSERT_NEXT(a_result_waits, (state_q == S_RESULT) && out_valid_o && !out_ready_i, state_q == S_RESULT)

endmodule

FILE: bench/fbba_alloc_checker.sv
// Checker for the fit-based block allocator: watches config writes and both channels.
// Predicts each result from its own copy of the size table; depends on fbba_pkg.
`timescale 1ns / 100ps

module fbba_alloc_checker
  import fbba_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  fbba_in_t              in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  fbba_out_t             out_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  logic [SIZE_BITS-1:0] orig_sz [NUM_BLOCKS];
  logic [SIZE_BITS-1:0] rem_sz  [NUM_BLOCKS];
  logic [MODE_W-1:0]    fit_sel;
  logic [BIU_W-1:0]     scan_count;
  fbba_out_t            grant_q [$];

  // Apply one transaction to the table copy and return the result it should give.
  function automatic fbba_out_t predict_grant(fbba_in_t item);
    fbba_out_t res;
    int        scan_len;
    int        k;
    int        pick;
    bit        found;
    res   = '0;
    pick  = 0;
    found = 1'b0;
    res.status = STS_DONE;
    case (item.op)
      OP_LOAD: begin
        orig_sz[item.block_index] = item.size_value;
        rem_sz[item.block_index]  = item.size_value;
      end
      OP_RESTORE: begin
        rem_sz = orig_sz;
      end
      OP_ALLOC: begin
        scan_len = (scan_count > NUM_BLOCKS) ? NUM_BLOCKS : int'(scan_count);
        for (k = 0; k < scan_len; k++) begin
          if (rem_sz[k] >= item.size_value) begin
            if (!found) begin
              pick  = k;
              found = 1'b1;
            end else if (fit_sel == FIT_BEST && rem_sz[k] < rem_sz[pick]) begin
              pick = k;
            end else if (fit_sel == FIT_WORST && rem_sz[k] > rem_sz[pick]) begin
              pick = k;
            end
          end
        end
        if (found) begin
          rem_sz[pick]        = rem_sz[pick] - item.size_value;
          res.status          = STS_ALLOC;
          res.chosen_block    = pick[BLK_W-1:0];
          res.remaining_after = rem_sz[pick];
        end else begin
          res.status = STS_NOFIT;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    fbba_out_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        orig_sz[i] = '0;
        rem_sz[i]  = '0;
      end
      fit_sel      = FIT_FIRST;
      scan_count   = BIU_RESET;
      grant_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_FIT_MODE) begin
          fit_sel = cfg_wdata_i[MODE_W-1:0];
        end else begin
          scan_count = cfg_wdata_i[BIU_W-1:0];
        end
      end
      // Results leave before new transactions enter: the oldest prediction is first.
      if (out_valid_i && out_ready_i) begin
        if (grant_q.size() == 0) begin
          $display("%0t unexpected result: status %0d block %0d remaining %0d", $time,
                   out_data_i.status, out_data_i.chosen_block, out_data_i.remaining_after);
          fail_count_o++;
        end else begin
          want = grant_q.pop_front();
          if (out_data_i.status !== want.status ||
              out_data_i.chosen_block !== want.chosen_block ||
              out_data_i.remaining_after !== want.remaining_after) begin
            $display("%0t mismatch: expected status %0d block %0d remaining %0d, got status %0d block %0d remaining %0d",
                     $time, want.status, want.chosen_block, want.remaining_after,
                     out_data_i.status, out_data_i.chosen_block, out_data_i.remaining_after);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        grant_q.push_back(predict_grant(in_data_i));
      end
      pending_o = grant_q.size();
    end
  end

endmodule

FILE: bench/tb.sv
// Testbench top for the fit-based block allocator: clock, reset, stimulus and verdict.
// Depends on fbba_pkg, the block and fbba_alloc_checker, which does all prediction.
`timescale 1ns / 100ps

module tb;
  import fbba_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  fbba_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  fbba_out_t             out_data;
  int                    fail_count;
  int                    pending;
  bit                    idle_en   = 1'b1;
  int                    stall_cycles = 0;

  fit_based_block_allocator u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  fbba_alloc_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 8 ns period: low half, then high half.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stall the result side about 17 percent of the time while idling is enabled.
  always @(negedge clk) begin
    out_ready <= idle_en ? ($urandom_range(99) >= 17) : 1'b1;
  end

  // Watchdog: end the run if nothing at all moves for too long.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("fit_based_block_allocator verification failed");
        $finish;
      end
    end
  end

  // Present one transaction and hold it until the block takes it. Return at a falling
  // edge with valid still high, so a following call can keep it high without a dip.
  task automatic send_op(logic [OP_W-1:0] op, logic [BLK_W-1:0] idx,
                         logic [SIZE_BITS-1:0] sz);
    fbba_in_t item;
    item.op          = op;
    item.block_index = idx;
    item.size_value  = sz;
    while (idle_en && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Write both registers on back-to-back cycles; call only with the block drained.
  task automatic write_config(logic [CFG_DATA_W-1:0] mode_val,
                              logic [CFG_DATA_W-1:0] scan_val);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_FIT_MODE;
    cfg_wdata <= mode_val;
    @(negedge clk);
    cfg_idx   <= CFG_BLOCKS_IN_USE;
    cfg_wdata <= scan_val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Sizes lean small so tables fill and empty often; extremes and full-width values
  // appear now and then so every bit toggles.
  function automatic logic [SIZE_BITS-1:0] pick_size(bit for_load);
    int unsigned p;
    p = $urandom_range(99);
    if (p < 4) return '1;
    if (p < 8) return '0;
    if (p < 15) return SIZE_BITS'($urandom);
    return for_load ? SIZE_BITS'($urandom_range(1200, 100)) : SIZE_BITS'($urandom_range(300));
  endfunction

  task automatic send_random();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 30) begin
      send_op(OP_LOAD, BLK_W'($urandom_range(NUM_BLOCKS - 1)), pick_size(1'b1));
    end else if (p < 85) begin
      send_op(OP_ALLOC, BLK_W'($urandom_range(NUM_BLOCKS - 1)), pick_size(1'b0));
    end else if (p < 95) begin
      send_op(OP_RESTORE, BLK_W'($urandom_range(NUM_BLOCKS - 1)), SIZE_BITS'($urandom));
    end else begin
      send_op(OP_UNUSED, BLK_W'($urandom_range(NUM_BLOCKS - 1)), SIZE_BITS'($urandom));
    end
  endtask

  initial begin
    int unsigned p;
    logic [CFG_DATA_W-1:0] mode_val;
    logic [CFG_DATA_W-1:0] scan_val;

    // Hold reset, then release it on a falling edge.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty table under reset config: a zero request fits block 0, nothing else fits.
    send_op(OP_ALLOC, 3'd0, 16'd0);
    send_op(OP_ALLOC, 3'd5, 16'd1);

    // Fill the table with ties and both size extremes.
    send_op(OP_LOAD, 3'd0, 16'd100);
    send_op(OP_LOAD, 3'd1, 16'hFFFF);
    send_op(OP_LOAD, 3'd2, 16'd50);
    send_op(OP_LOAD, 3'd3, 16'd200);
    send_op(OP_LOAD, 3'd4, 16'd50);
    send_op(OP_LOAD, 3'd5, 16'd0);
    send_op(OP_LOAD, 3'd6, 16'd300);
    send_op(OP_LOAD, 3'd7, 16'hFFFF);

    // First fit: a full-range request, then a small one; then the unused op and a restore.
    send_op(OP_ALLOC, 3'd7, 16'hFFFF);
    send_op(OP_ALLOC, 3'd0, 16'd60);
    send_op(OP_UNUSED, 3'd7, 16'hFFFF);
    send_op(OP_RESTORE, 3'd2, 16'h1234);

    // Best fit: equal sizes tie to the lowest index.
    drain();
    write_config(CFG_DATA_W'(FIT_BEST), 4'd8);
    send_op(OP_ALLOC, 3'd0, 16'd50);
    send_op(OP_ALLOC, 3'd0, 16'd50);

    // Worst fit: tie on the largest, then the zero request takes the new largest.
    drain();
    write_config(CFG_DATA_W'(FIT_WORST), 4'd8);
    send_op(OP_ALLOC, 3'd0, 16'd1);
    send_op(OP_ALLOC, 3'd0, 16'd0);

    // Unused mode acts as first fit; a scan count past the table saturates.
    drain();
    write_config(4'd3, 4'd15);
    send_op(OP_ALLOC, 3'd0, 16'd40);

    // No blocks in use: nothing can fit.
    drain();
    write_config(CFG_DATA_W'(FIT_FIRST), 4'd0);
    send_op(OP_ALLOC, 3'd0, 16'd0);

    // Single block in use.
    drain();
    write_config(CFG_DATA_W'(FIT_BEST), 4'd1);
    send_op(OP_ALLOC, 3'd0, 16'd10);

    // Random phases, each under a fresh config; one phase runs with no idling at all.
    for (int phase = 0; phase < 13; phase++) begin
      drain();
      idle_en = (phase != 6);
      p = $urandom_range(99);
      mode_val = (p < 85) ? CFG_DATA_W'($urandom_range(2)) : 4'd3;
      p = $urandom_range(99);
      if (p < 70) begin
        scan_val = CFG_DATA_W'($urandom_range(NUM_BLOCKS, 1));
      end else if (p < 80) begin
        scan_val = CFG_DATA_W'(NUM_BLOCKS);
      end else if (p < 90) begin
        scan_val = '0;
      end else begin
        scan_val = CFG_DATA_W'($urandom_range(15, NUM_BLOCKS + 1));
      end
      write_config(mode_val, scan_val);
      repeat (100) send_random();
    end

    // Wait out every result, then let the block run on idle before the verdict.
    drain();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("fit_based_block_allocator verification clean");
    end else begin
      $display("fit_based_block_allocator verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/fbba_pkg.sv
design/fbba_ram.sv
design/fit_based_block_allocator.sv
bench/fbba_alloc_checker.sv
bench/tb.sv
